[src/scot_pkg.sv]
// shared types and constants for the sphere overlap test pipeline
// no dependencies; imported by scot_sq and sphere_collider_overlap_test_unit
package scot_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int ROT_BITS_DEF   = 18;

    // fixed field widths of the item
    localparam int RADIUS_BITS  = 20;
    localparam int SCALE_BITS   = 16;
    localparam int VEC_BITS     = 60;
    localparam int ROT_ROW_BITS = 54;

    // default width of a squared operand (oriented box distance)
    localparam int SQ_BITS_DEF = COORD_BITS_DEF + ROT_BITS_DEF + 2;

    typedef enum logic [1:0] {
        CMD_AXIS_BOX     = 2'd0,
        CMD_ORIENTED_BOX = 2'd1,
        CMD_SPHERE       = 2'd2,
        CMD_NONE         = 2'd3
    } cmd_t;

    // stage advance controls handed to a split squarer
    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } sq_ctl_t;

endpackage

[src/sphere_collider_overlap_test_unit.sv]
// sphere against axis box, oriented box or sphere overlap test, eight-stage pipeline
// depends on scot_pkg and scot_sq
//
// usage: one item on the request channel (req_valid/req_stall) carries the command,
// both shapes and the box rotation; one item leaves on the response channel
// (rsp_valid/rsp_stall) carrying hit, in the order items came in.
// stages: the item passes eight register stages (prep, rotation products,
// dot sums, clamp, two squarer stages, sum of squares, compare).
// throughput: one item per cycle while the receiver does not stall; the widest
// operations are the split squarers, cut into two stages of 22x22 partial
// products at most.
// stall: each stage advances when it is empty or the next one advances, so
// bubbles close up; req_stall rises only when all eight stages hold items and
// the receiver stalls. a stalled result holds in the output register.
// reset: rst_n clears all stage valid bits; the pipeline comes up empty and
// accepts an item in the first cycle after reset.
module sphere_collider_overlap_test_unit
    import scot_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ROT_BITS   = ROT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [1:0]              command,
    input  logic [VEC_BITS-1:0]     own_center,
    input  logic [RADIUS_BITS-1:0]  own_radius,
    input  logic [SCALE_BITS-1:0]   own_scale,
    input  logic [VEC_BITS-1:0]     other_center,
    input  logic [VEC_BITS-1:0]     other_size,
    input  logic [SCALE_BITS-1:0]   other_scale,
    input  logic [ROT_ROW_BITS-1:0] rot_row_x,
    input  logic [ROT_ROW_BITS-1:0] rot_row_y,
    input  logic [ROT_ROW_BITS-1:0] rot_row_z,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    hit
);

    localparam int CB      = COORD_BITS;
    localparam int RB      = ROT_BITS;
    localparam int RF      = RB - 2;
    localparam int CW      = (3 * CB > VEC_BITS) ? 3 * CB : VEC_BITS;
    localparam int TW      = CB + 1;
    localparam int AW      = CB + 3;
    localparam int ADW     = CB + 2;
    localparam int PW      = TW + RB;
    localparam int DOTW    = PW + 2;
    localparam int OW      = DOTW + 1;
    localparam int DMW     = CB + RB + 2;
    localparam int WRW     = RADIUS_BITS + SCALE_BITS;
    localparam int WR2W    = CB + SCALE_BITS;
    localparam int RSH     = RF - 8;
    localparam int RW_OBOX = WRW + RSH;
    localparam int RW_SPH  = ((WRW > WR2W) ? WRW : WR2W) + 1;
    localparam int RW      = (RW_OBOX > RW_SPH) ? RW_OBOX : RW_SPH;
    localparam int LW      = 2 * DMW + 2;
    localparam int CMPW    = (LW > 2 * RW) ? LW : 2 * RW;
    localparam int NST     = 8;

    // pipeline control
    logic [NST:1] v_reg;
    logic [NST:1] adv;
    sq_ctl_t      sq_ctl;

    // lane views of the packed fields
    logic [CW-1:0]          oc_ext, ot_ext, sz_ext;
    logic signed [CB-1:0]   oc_l [3];
    logic signed [CB-1:0]   ot_l [3];
    logic [CB-1:0]          sz_l [3];
    logic signed [RB-1:0]   rot_l [3][3];

    // stage 1
    cmd_t                   cmd1_reg, cmd1_next;
    logic [WRW-1:0]         wr1_reg, wr1_next;
    logic [WR2W-1:0]        wr2_1_reg, wr2_1_next;
    logic signed [TW-1:0]   t1_reg [3];
    logic signed [TW-1:0]   t1_next [3];
    logic [ADW-1:0]         ad1_reg [3];
    logic [ADW-1:0]         ad1_next [3];
    logic [CB-1:0]          sz1_reg [3];
    logic signed [RB-1:0]   rot1_reg [3][3];

    // stage 2
    cmd_t                   cmd2_reg;
    logic [RW-1:0]          r2_reg, r2_next;
    logic signed [PW-1:0]   prod2_reg [3][3];
    logic signed [PW-1:0]   prod2_next [3][3];
    logic [DMW-1:0]         sd2_reg [3];
    logic [DMW-1:0]         sd2_next [3];
    logic [CB-1:0]          sz2_reg [3];

    // stage 3
    cmd_t                   cmd3_reg;
    logic [RW-1:0]          r3_reg;
    logic signed [DOTW-1:0] dot3_reg [3];
    logic signed [DOTW-1:0] dot3_next [3];
    logic [DMW-1:0]         sd3_reg [3];
    logic [CB-1:0]          sz3_reg [3];

    // stage 4
    cmd_t                   cmd4_reg;
    logic [RW-1:0]          r4_reg;
    logic [DMW-1:0]         d4_reg [3];
    logic [DMW-1:0]         d4_next [3];

    // stages 5 and 6 live in the squarers
    cmd_t                   cmd5_reg, cmd6_reg;
    logic [2*DMW-1:0]       dsq [3];
    logic [2*RW-1:0]        rsq;

    // stage 7 and the output stage
    cmd_t                   cmd7_reg;
    logic [CMPW-1:0]        lhs7_reg, lhs7_next;
    logic [CMPW-1:0]        rhs7_reg, rhs7_next;
    logic                   hit_reg, hit_next;

    // stage advance: a stage moves when it is empty or its successor moves
    always_comb
    begin
        adv[NST] = !v_reg[NST] || !rsp_stall;
        for (int k = NST - 1; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        sq_ctl.adv_a = adv[5];
        sq_ctl.adv_b = adv[6];
    end

    assign req_stall = !adv[1];
    assign rsp_valid = v_reg[NST];
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= req_valid;
            end
            for (int k = 2; k <= NST; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: lanes, world radii, offsets, axis box distance
    assign oc_ext = CW'(own_center);
    assign ot_ext = CW'(other_center);
    assign sz_ext = CW'(other_size);

    always_comb
    begin
        logic signed [AW-1:0] c2, o2, len, lo, hi, diff;
        for (int i = 0; i < 3; i++)
        begin
            oc_l[i]     = oc_ext[i*CB +: CB];
            ot_l[i]     = ot_ext[i*CB +: CB];
            sz_l[i]     = sz_ext[i*CB +: CB];
            rot_l[0][i] = rot_row_x[i*RB +: RB];
            rot_l[1][i] = rot_row_y[i*RB +: RB];
            rot_l[2][i] = rot_row_z[i*RB +: RB];
        end
        cmd1_next  = cmd_t'(command);
        wr1_next   = WRW'(own_radius) * WRW'(own_scale);
        wr2_1_next = WR2W'(sz_l[0]) * WR2W'(other_scale);
        for (int i = 0; i < 3; i++)
        begin
            t1_next[i] = TW'(oc_l[i]) - TW'(ot_l[i]);
            // axis box at half-lsb resolution so half lengths stay exact
            c2  = AW'(oc_l[i]) <<< 1;
            o2  = AW'(ot_l[i]) <<< 1;
            len = AW'(sz_l[i]);
            lo  = o2 - len;
            hi  = o2 + len;
            if (c2 < lo)
            begin
                diff = lo - c2;
            end
            else if (c2 > hi)
            begin
                diff = c2 - hi;
            end
            else
            begin
                diff = '0;
            end
            ad1_next[i] = diff[ADW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            cmd1_reg  <= cmd1_next;
            wr1_reg   <= wr1_next;
            wr2_1_reg <= wr2_1_next;
            for (int i = 0; i < 3; i++)
            begin
                t1_reg[i]  <= t1_next[i];
                ad1_reg[i] <= ad1_next[i];
                sz1_reg[i] <= sz_l[i];
                for (int k = 0; k < 3; k++)
                begin
                    rot1_reg[k][i] <= rot_l[k][i];
                end
            end
        end
    end

    // stage 2: rotation products, radius by kind, axis and sphere distances
    always_comb
    begin
        logic [TW-1:0] tmag;
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod2_next[k][i] = PW'(t1_reg[i]) * PW'(rot1_reg[k][i]);
            end
        end
        case (cmd1_reg)
            CMD_AXIS_BOX:     r2_next = RW'(wr1_reg);
            CMD_ORIENTED_BOX: r2_next = RW'(wr1_reg) << RSH;
            CMD_SPHERE:       r2_next = RW'(wr1_reg) + RW'(wr2_1_reg);
            default:          r2_next = '0;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            tmag = t1_reg[i][TW-1] ? TW'(-t1_reg[i]) : TW'(t1_reg[i]);
            case (cmd1_reg)
                CMD_AXIS_BOX: sd2_next[i] = DMW'(ad1_reg[i]) << 7;
                CMD_SPHERE:   sd2_next[i] = DMW'(tmag) << 8;
                default:      sd2_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            cmd2_reg <= cmd1_reg;
            r2_reg   <= r2_next;
            for (int k = 0; k < 3; k++)
            begin
                sd2_reg[k] <= sd2_next[k];
                sz2_reg[k] <= sz1_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    prod2_reg[k][i] <= prod2_next[k][i];
                end
            end
        end
    end

    // stage 3: box-frame coordinates
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dot3_next[k] = DOTW'(prod2_reg[k][0]) + DOTW'(prod2_reg[k][1])
                         + DOTW'(prod2_reg[k][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            cmd3_reg <= cmd2_reg;
            r3_reg   <= r2_reg;
            for (int k = 0; k < 3; k++)
            begin
                dot3_reg[k] <= dot3_next[k];
                sd3_reg[k]  <= sd2_reg[k];
                sz3_reg[k]  <= sz2_reg[k];
            end
        end
    end

    // stage 4: oriented box clamp against the half extents
    always_comb
    begin
        logic signed [OW-1:0] extv, sp, sm;
        for (int k = 0; k < 3; k++)
        begin
            extv = OW'(sz3_reg[k]) << RF;
            sp   = OW'(dot3_reg[k]) + extv;
            sm   = OW'(dot3_reg[k]) - extv;
            if (cmd3_reg == CMD_ORIENTED_BOX)
            begin
                if (sp < 0)
                begin
                    d4_next[k] = DMW'(-sp);
                end
                else if (sm > 0)
                begin
                    d4_next[k] = DMW'(sm);
                end
                else
                begin
                    d4_next[k] = '0;
                end
            end
            else
            begin
                d4_next[k] = sd3_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            cmd4_reg <= cmd3_reg;
            r4_reg   <= r3_reg;
            for (int k = 0; k < 3; k++)
            begin
                d4_reg[k] <= d4_next[k];
            end
        end
    end

    // stages 5 and 6: squares of the three distances and of the radius
    for (genvar g = 0; g < 3; g++)
    begin : g_dsq
        scot_sq #(
            .W (DMW)
        ) u_sq_d (
            .clk (clk),
            .ctl (sq_ctl),
            .a   (d4_reg[g]),
            .sq  (dsq[g])
        );
    end

    scot_sq #(
        .W (RW)
    ) u_sq_r (
        .clk (clk),
        .ctl (sq_ctl),
        .a   (r4_reg),
        .sq  (rsq)
    );

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            cmd5_reg <= cmd4_reg;
        end
        if (adv[6])
        begin
            cmd6_reg <= cmd5_reg;
        end
    end

    // stage 7: sum of squares
    always_comb
    begin
        lhs7_next = CMPW'(dsq[0]) + CMPW'(dsq[1]) + CMPW'(dsq[2]);
        rhs7_next = CMPW'(rsq);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            cmd7_reg <= cmd6_reg;
            lhs7_reg <= lhs7_next;
            rhs7_reg <= rhs7_next;
        end
    end

    // stage 8: boxes hit on touch, spheres need strict overlap
    always_comb
    begin
        case (cmd7_reg)
            CMD_AXIS_BOX:     hit_next = (lhs7_reg <= rhs7_reg);
            CMD_ORIENTED_BOX: hit_next = (lhs7_reg <= rhs7_reg);
            CMD_SPHERE:       hit_next = (lhs7_reg < rhs7_reg);
            default:          hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

[src/scot_sq.sv]
// two-stage split squarer: partial products, then recombination
// depends on scot_pkg
module scot_sq
    import scot_pkg::*;
#(
    parameter int W = SQ_BITS_DEF
)
(
    input  logic             clk,
    input  sq_ctl_t          ctl,
    input  logic [W-1:0]     a,
    output logic [2*W-1:0]   sq
);

    localparam int L   = (W + 1) / 2;
    localparam int HW  = W - L;
    localparam int PLW = 2 * L;
    localparam int PHW = 2 * HW;
    localparam int SW  = 2 * W;

    logic [L-1:0]   lo;
    logic [HW-1:0]  hi;
    logic [PLW-1:0] pll_reg, pll_next;
    logic [W-1:0]   plh_reg, plh_next;
    logic [PHW-1:0] phh_reg, phh_next;
    logic [SW-1:0]  sq_reg, sq_next;

    always_comb
    begin
        lo       = a[L-1:0];
        hi       = a[W-1:L];
        pll_next = PLW'(lo) * PLW'(lo);
        plh_next = W'(lo) * W'(hi);
        phh_next = PHW'(hi) * PHW'(hi);
        // cross term appears twice, hence one extra bit of shift
        sq_next  = (SW'(phh_reg) << (2 * L)) + (SW'(plh_reg) << (L + 1)) + SW'(pll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv_a)
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phh_reg <= phh_next;
        end
        if (ctl.adv_b)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;

endmodule
